@@ src/dsm_pkg.sv @@
// ============================================================================
// DFA state minimizer package
// Shared widths, operation codes, register indexes and sequencer states.
// ============================================================================
package dsm_pkg;

   localparam int MAX_STATES  = 32;
   localparam int MAX_SYMBOLS = 8;

   localparam int STATE_W    = $clog2(MAX_STATES);
   localparam int SYMBOL_W   = $clog2(MAX_SYMBOLS);
   localparam int TBL_ADDR_W = STATE_W + SYMBOL_W;
   localparam int TBL_DEPTH  = MAX_STATES * MAX_SYMBOLS;
   localparam int CNT_W      = $clog2(MAX_STATES + 1);
   localparam int SIG_W      = STATE_W + 1;

   localparam int NUM_STATES_W  = 6;
   localparam int NUM_SYMBOLS_W = 4;
   localparam int ACTION_W      = 2;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 6;

   localparam logic [ACTION_W-1:0] ACT_SET_ACCEPT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE_TRAN = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RUN        = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STATES  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SYMBOLS = 4'd1;

   localparam logic [SIG_W-1:0] DEAD_SIG = {1'b1, {STATE_W{1'b0}}};

   typedef enum logic [13:0] {
      ST_IDLE        = 14'b00000000000001,
      ST_INIT        = 14'b00000000000010,
      ST_SIG_TRAN    = 14'b00000000000100,
      ST_SIG_CLASS   = 14'b00000000001000,
      ST_SIG_WRITE   = 14'b00000000010000,
      ST_CMP_CLASS   = 14'b00000000100000,
      ST_CMP_CLS_CHK = 14'b00000001000000,
      ST_CMP_SIG     = 14'b00000010000000,
      ST_CMP_SIG_CHK = 14'b00000100000000,
      ST_CMP_WRITE   = 14'b00001000000000,
      ST_ROUND_END   = 14'b00010000000000,
      ST_OUT_READ    = 14'b00100000000000,
      ST_OUT_LOAD    = 14'b01000000000000,
      ST_OUT_WAIT    = 14'b10000000000000
   } seq_state_type;

endpackage

@@ src/dsm_if.sv @@
// ============================================================================
// DFA state minimizer channels
// Request, response and register write channels with valid/ready handshake.
// ============================================================================
interface dsm_req_if import dsm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [STATE_W-1:0]  state_index;
   logic [SYMBOL_W-1:0] symbol;
   logic [STATE_W-1:0]  target;
   logic                accepting;

   modport source (output valid, action, state_index, symbol, target, accepting,
                   input ready);
   modport sink (input valid, action, state_index, symbol, target, accepting,
                 output ready);
endinterface

interface dsm_rsp_if import dsm_pkg::*;;
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] state_out;
   logic [STATE_W-1:0] representative;
   logic               is_representative;
   logic               last;

   modport source (output valid, state_out, representative, is_representative, last,
                   input ready);
   modport sink (input valid, state_out, representative, is_representative, last,
                 output ready);
endinterface

interface dsm_csr_if import dsm_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/dfa_state_minimizer_core.sv @@
// ============================================================================
// DFA state minimizer core
// Load beats are taken while the block is idle. A run beat first labels the n
// states by acceptance, then repeats refinement rounds until the class count
// stays put. Each round builds a signature table with one shared read chain
// (transition, class and write steps per state and symbol) and then searches,
// for each state, the lowest state with the same class and signature,
// comparing one symbol at a time through the dual-read signature memory.
// Results leave one beat per state, each loaded only after the previous beat
// is taken. The block takes no request until the last result beat.
// ============================================================================
module dfa_state_minimizer_core import dsm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   dsm_req_if.sink   req_if,
   dsm_rsp_if.source rsp_if,
   dsm_csr_if.sink   csr_if
);

   seq_state_type state_ff, state_in;

   logic [NUM_STATES_W-1:0]  num_states_ff;
   logic [NUM_SYMBOLS_W-1:0] num_symbols_ff;
   logic [MAX_STATES-1:0]    acc_ff;
   logic [TBL_DEPTH-1:0]     tvalid_ff;

   logic [STATE_W-1:0]       trans_mem [TBL_DEPTH];
   logic [SIG_W-1:0]         sig_mem   [TBL_DEPTH];
   logic [STATE_W-1:0]       class_mem [2*MAX_STATES];

   logic [STATE_W-1:0]  s_ff, s_in, t_ff, t_in, first_ff, first_in;
   logic [SYMBOL_W-1:0] k_ff, k_in;
   logic                bank_ff, bank_in, found_ff, found_in;
   logic [CNT_W-1:0]    count_ff, count_in, new_count_ff, new_count_in;
   logic [NUM_STATES_W-1:0]  n_ff, n_in;
   logic [NUM_SYMBOLS_W-1:0] m_ff, m_in;

   logic [STATE_W-1:0] trans_q_ff, cls_a_ff, cls_b_ff;
   logic               tv_q_ff;
   logic [SIG_W-1:0]   sig_a_ff, sig_b_ff;

   logic [STATE_W-1:0] out_state_ff, out_state_in, out_rep_ff, out_rep_in;
   logic               out_isrep_ff, out_isrep_in, out_last_ff, out_last_in;

   logic                  req_beat, last_s, last_k, diff, cls_we;
   logic [STATE_W:0]      cls_waddr, cls_raddr_a, cls_raddr_b;
   logic [STATE_W-1:0]    cls_wdata, init_cls;
   logic [TBL_ADDR_W-1:0] sk_addr, tk_addr, req_addr;
   logic [SIG_W-1:0]      sig_wdata;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_beat     = req_if.valid && req_if.ready;

   assign rsp_if.valid             = (state_ff == ST_OUT_WAIT);
   assign rsp_if.state_out         = out_state_ff;
   assign rsp_if.representative    = out_rep_ff;
   assign rsp_if.is_representative = out_isrep_ff;
   assign rsp_if.last              = out_last_ff;

   assign last_s   = ({1'b0, s_ff} + NUM_STATES_W'(1)) == n_ff;
   assign last_k   = ({1'b0, k_ff} + NUM_SYMBOLS_W'(1)) == m_ff;
   assign sk_addr  = {s_ff, k_ff};
   assign tk_addr  = {t_ff, k_ff};
   assign req_addr = {req_if.state_index, req_if.symbol};
   assign diff     = acc_ff[s_ff] != acc_ff[0];
   assign init_cls = !diff ? STATE_W'(0) : (found_ff ? first_ff : s_ff);

   assign sig_wdata = (!tv_q_ff || ({1'b0, trans_q_ff} >= n_ff)) ?
                      DEAD_SIG : {1'b0, cls_a_ff};

   always_comb begin
      cls_we    = (state_ff == ST_INIT) || (state_ff == ST_CMP_WRITE);
      cls_waddr = (state_ff == ST_INIT) ? {bank_ff, s_ff} : {~bank_ff, s_ff};
      cls_wdata = (state_ff == ST_INIT) ? init_cls : t_ff;
      if (state_ff == ST_SIG_CLASS) begin
         cls_raddr_a = {bank_ff, trans_q_ff};
      end else if (state_ff == ST_CMP_CLASS) begin
         cls_raddr_a = {bank_ff, t_ff};
      end else begin
         cls_raddr_a = {bank_ff, s_ff};
      end
      cls_raddr_b = {bank_ff, s_ff};
   end

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      bank_in      = bank_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      new_count_in = new_count_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      out_state_in = out_state_ff;
      out_rep_in   = out_rep_ff;
      out_isrep_in = out_isrep_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_if.action == ACT_RUN) begin
               if (num_states_ff == '0) begin
                  n_in = NUM_STATES_W'(1);
               end else if (num_states_ff > NUM_STATES_W'(MAX_STATES)) begin
                  n_in = NUM_STATES_W'(MAX_STATES);
               end else begin
                  n_in = num_states_ff;
               end
               if (num_symbols_ff == '0) begin
                  m_in = NUM_SYMBOLS_W'(1);
               end else if (num_symbols_ff > NUM_SYMBOLS_W'(MAX_SYMBOLS)) begin
                  m_in = NUM_SYMBOLS_W'(MAX_SYMBOLS);
               end else begin
                  m_in = num_symbols_ff;
               end
               s_in     = '0;
               found_in = 1'b0;
               first_in = '0;
               bank_in  = 1'b0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            found_in = found_ff || diff;
            if (diff && !found_ff) begin
               first_in = s_ff;
            end
            if (last_s) begin
               count_in     = (found_ff || diff) ? CNT_W'(2) : CNT_W'(1);
               new_count_in = '0;
               s_in         = '0;
               k_in         = '0;
               state_in     = ST_SIG_TRAN;
            end else begin
               s_in = s_ff + STATE_W'(1);
            end
         end
         ST_SIG_TRAN: begin
            state_in = ST_SIG_CLASS;
         end
         ST_SIG_CLASS: begin
            state_in = ST_SIG_WRITE;
         end
         ST_SIG_WRITE: begin
            if (last_k) begin
               k_in = '0;
               if (last_s) begin
                  s_in     = '0;
                  t_in     = '0;
                  state_in = ST_CMP_CLASS;
               end else begin
                  s_in     = s_ff + STATE_W'(1);
                  state_in = ST_SIG_TRAN;
               end
            end else begin
               k_in     = k_ff + SYMBOL_W'(1);
               state_in = ST_SIG_TRAN;
            end
         end
         ST_CMP_CLASS: begin
            state_in = (t_ff == s_ff) ? ST_CMP_WRITE : ST_CMP_CLS_CHK;
         end
         ST_CMP_CLS_CHK: begin
            if (cls_a_ff != cls_b_ff) begin
               t_in     = t_ff + STATE_W'(1);
               state_in = ST_CMP_CLASS;
            end else begin
               k_in     = '0;
               state_in = ST_CMP_SIG;
            end
         end
         ST_CMP_SIG: begin
            state_in = ST_CMP_SIG_CHK;
         end
         ST_CMP_SIG_CHK: begin
            if (sig_a_ff != sig_b_ff) begin
               t_in     = t_ff + STATE_W'(1);
               state_in = ST_CMP_CLASS;
            end else if (last_k) begin
               state_in = ST_CMP_WRITE;
            end else begin
               k_in     = k_ff + SYMBOL_W'(1);
               state_in = ST_CMP_SIG;
            end
         end
         ST_CMP_WRITE: begin
            if (t_ff == s_ff) begin
               new_count_in = new_count_ff + CNT_W'(1);
            end
            t_in = '0;
            if (last_s) begin
               state_in = ST_ROUND_END;
            end else begin
               s_in     = s_ff + STATE_W'(1);
               state_in = ST_CMP_CLASS;
            end
         end
         ST_ROUND_END: begin
            bank_in = ~bank_ff;
            s_in    = '0;
            k_in    = '0;
            if (new_count_ff == count_ff) begin
               state_in = ST_OUT_READ;
            end else begin
               count_in     = new_count_ff;
               new_count_in = '0;
               state_in     = ST_SIG_TRAN;
            end
         end
         ST_OUT_READ: begin
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            out_state_in = s_ff;
            out_rep_in   = cls_a_ff;
            out_isrep_in = cls_a_ff == s_ff;
            out_last_in  = last_s;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_if.ready) begin
               if (last_s) begin
                  state_in = ST_IDLE;
               end else begin
                  s_in     = s_ff + STATE_W'(1);
                  state_in = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         num_states_ff  <= NUM_STATES_W'(MAX_STATES);
         num_symbols_ff <= NUM_SYMBOLS_W'(MAX_SYMBOLS);
         acc_ff         <= '0;
         tvalid_ff      <= '0;
         count_ff       <= '0;
         new_count_ff   <= '0;
         bank_ff        <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         new_count_ff <= new_count_in;
         bank_ff      <= bank_in;
         found_ff     <= found_in;
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_NUM_STATES) begin
               num_states_ff <= csr_if.data[NUM_STATES_W-1:0];
            end else if (csr_if.index == CSR_NUM_SYMBOLS) begin
               num_symbols_ff <= csr_if.data[NUM_SYMBOLS_W-1:0];
            end
         end
         if (req_beat && req_if.action == ACT_SET_ACCEPT) begin
            acc_ff[req_if.state_index] <= req_if.accepting;
         end
         if (req_beat && req_if.action == ACT_WRITE_TRAN) begin
            tvalid_ff[req_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      first_ff     <= first_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      out_state_ff <= out_state_in;
      out_rep_ff   <= out_rep_in;
      out_isrep_ff <= out_isrep_in;
      out_last_ff  <= out_last_in;
      tv_q_ff      <= tvalid_ff[sk_addr];
   end

   always_ff @(posedge clock) begin
      if (req_beat && req_if.action == ACT_WRITE_TRAN) begin
         trans_mem[req_addr] <= req_if.target;
      end
      trans_q_ff <= trans_mem[sk_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SIG_WRITE) begin
         sig_mem[sk_addr] <= sig_wdata;
      end
      sig_a_ff <= sig_mem[tk_addr];
      sig_b_ff <= sig_mem[sk_addr];
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         class_mem[cls_waddr] <= cls_wdata;
      end
      cls_a_ff <= class_mem[cls_raddr_a];
      cls_b_ff <= class_mem[cls_raddr_b];
   end

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request taken while a result beat is pending");

   a_search_below_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP_CLASS || state_ff == ST_CMP_CLS_CHK ||
       state_ff == ST_CMP_SIG || state_ff == ST_CMP_SIG_CHK ||
       state_ff == ST_CMP_WRITE) |-> t_ff <= s_ff)
      else $error("class search passed the state being labeled");

   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND_END) |-> new_count_ff >= count_ff)
      else $error("refinement round merged classes");

endmodule
